>>> sv/mcprb_pkg.sv
// Shared types, codes and sizes for the multichannel partitioned ring buffer.
// Used by mcprb_front, mcprb_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package mcprb_pkg;

   // Field and store widths
   localparam int ACTION_W   = 2;
   localparam int CHAN_W     = 3;
   localparam int DATA_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int SIZE_W     = 14;
   localparam int PTR_W      = 13;
   localparam int SUM_W      = SIZE_W + CHAN_W;
   localparam int REG_COUNT  = 8;
   localparam int REG_IDX_W  = 3;
   localparam int KIND_W     = 3;

   localparam logic [SIZE_W-1:0] MAX_CHAN_SIZE = SIZE_W'(8192);

   // Default parameter values
   localparam int DEF_CHANNEL_COUNT = 8;
   localparam int DEF_MEM_DEPTH     = 8192;

   // Action codes of an input word
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

   // Status codes of a result word
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERWRITE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNSIZED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LAYOUT    = 3'd4;

   // Command kinds after classification
   localparam logic [KIND_W-1:0] K_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] K_READ   = 3'd1;
   localparam logic [KIND_W-1:0] K_INIT   = 3'd2;
   localparam logic [KIND_W-1:0] K_PEEK   = 3'd3;  // no-op on a channel in range
   localparam logic [KIND_W-1:0] K_REJECT = 3'd4;  // write or read past the channel count
   localparam logic [KIND_W-1:0] K_NULL   = 3'd5;  // no-op past the channel count

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAN_W-1:0]   channel;
      logic [DATA_W-1:0]   wdata;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   rdata;
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   fill;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] chan;
      logic [DATA_W-1:0] wdata;
   } cmd_type;

endpackage

>>> sv/mcprb_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
// Depends on mcprb_pkg.
`timescale 1ns / 1ps

module mcprb_front #(
   parameter int CHANNEL_COUNT = mcprb_pkg::DEF_CHANNEL_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mcprb_pkg::req_type  req_data,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output mcprb_pkg::cmd_type  cmd
);

   mcprb_pkg::cmd_type q_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       in_range;
   mcprb_pkg::cmd_type cls;

   assign in_range = {1'b0, req_data.channel} < 4'(CHANNEL_COUNT);

   always_comb begin
      cls.chan  = req_data.channel;
      cls.wdata = req_data.wdata;
      unique case (req_data.action)
         mcprb_pkg::ACT_WRITE: cls.kind = in_range ? mcprb_pkg::K_WRITE : mcprb_pkg::K_REJECT;
         mcprb_pkg::ACT_READ:  cls.kind = in_range ? mcprb_pkg::K_READ : mcprb_pkg::K_REJECT;
         mcprb_pkg::ACT_INIT:  cls.kind = mcprb_pkg::K_INIT;
         default:              cls.kind = in_range ? mcprb_pkg::K_PEEK : mcprb_pkg::K_NULL;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (cmd_pop) begin
            rp_ff <= !rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

>>> sv/mcprb_back.sv
// Back end: channel pointers, the shared byte memory, layout walk and result register.
// Depends on mcprb_pkg.
`timescale 1ns / 1ps

module mcprb_back #(
   parameter int CHANNEL_COUNT = mcprb_pkg::DEF_CHANNEL_COUNT,
   parameter int MEM_DEPTH     = mcprb_pkg::DEF_MEM_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_pop,
   input  mcprb_pkg::cmd_type               cmd,
   input  logic                             csr_we,
   input  logic [mcprb_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mcprb_pkg::SIZE_W-1:0]     csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mcprb_pkg::rsp_type               rsp_data
);

   localparam int CHW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int AW  = $clog2(MEM_DEPTH);
   localparam int BW  = AW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   mcprb_pkg::cmd_type cmd_ff;

   logic [CHW-1:0]                 walk_ff;
   logic [mcprb_pkg::SUM_W-1:0]    sum_ff;
   logic [mcprb_pkg::SUM_W-1:0]    sum_in;
   logic                           bad_ff;
   logic                           bad_in;
   logic                           ready_ff;

   logic [mcprb_pkg::SIZE_W-1:0] size_ff [mcprb_pkg::REG_COUNT];
   logic [mcprb_pkg::SIZE_W-1:0] cap_ff  [CHANNEL_COUNT];
   logic [BW-1:0]                base_ff [CHANNEL_COUNT];
   logic [mcprb_pkg::PTR_W-1:0]  head_ff [CHANNEL_COUNT];
   logic [mcprb_pkg::PTR_W-1:0]  tail_ff [CHANNEL_COUNT];
   logic [mcprb_pkg::SIZE_W-1:0] fill_ff [CHANNEL_COUNT];

   logic [mcprb_pkg::DATA_W-1:0] mem [MEM_DEPTH];
   logic [mcprb_pkg::DATA_W-1:0] mem_q_ff;

   logic [mcprb_pkg::STATUS_W-1:0] pend_status_ff;
   logic [mcprb_pkg::STATUS_W-1:0] pend_status_in;
   logic [mcprb_pkg::SIZE_W-1:0]   pend_fill_ff;
   logic [mcprb_pkg::SIZE_W-1:0]   pend_fill_in;
   logic                           pend_read_ff;

   logic                rsp_valid_ff;
   mcprb_pkg::rsp_type  rsp_ff;

   logic                           send;
   logic [CHW-1:0]                 sel;
   logic [mcprb_pkg::SIZE_W-1:0]   cap;
   logic [mcprb_pkg::SIZE_W-1:0]   fill;
   logic [mcprb_pkg::PTR_W-1:0]    head;
   logic [mcprb_pkg::PTR_W-1:0]    tail;
   logic [mcprb_pkg::PTR_W-1:0]    ptr;
   logic [BW-1:0]                  addr_sum;
   logic [AW-1:0]                  mem_addr;
   logic                           live;
   logic                           full;
   logic                           empty;
   logic                           mem_we;
   logic                           mem_re;
   logic                           chan_we;
   logic [mcprb_pkg::PTR_W-1:0]    head_in;
   logic [mcprb_pkg::PTR_W-1:0]    tail_in;
   logic [mcprb_pkg::SIZE_W-1:0]   fill_in;
   logic [mcprb_pkg::SIZE_W-1:0]   wsize;
   logic                           walk_last;
   logic                           layout_bad;

   // Step a pointer forward modulo the channel capacity
   function automatic logic [mcprb_pkg::PTR_W-1:0] wrap(
      input logic [mcprb_pkg::PTR_W-1:0]  p,
      input logic [mcprb_pkg::SIZE_W-1:0] c
   );
      logic [mcprb_pkg::SIZE_W-1:0] nx;
      nx = mcprb_pkg::SIZE_W'(p) + mcprb_pkg::SIZE_W'(1);
      wrap = (nx == c) ? '0 : nx[mcprb_pkg::PTR_W-1:0];
   endfunction

   assign send    = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = cmd_valid && ((state_ff == S_IDLE) || send);

   assign sel   = cmd_ff.chan[CHW-1:0];
   assign cap   = cap_ff[sel];
   assign fill  = fill_ff[sel];
   assign head  = head_ff[sel];
   assign tail  = tail_ff[sel];
   assign live  = ready_ff && (cap != '0);
   assign full  = (fill >= cap);
   assign empty = (fill == '0);

   assign ptr      = (cmd_ff.kind == mcprb_pkg::K_WRITE) ? tail : head;
   assign addr_sum = base_ff[sel] + BW'(ptr);
   assign mem_addr = addr_sum[AW-1:0];

   assign mem_we  = (state_ff == S_EXEC) && (cmd_ff.kind == mcprb_pkg::K_WRITE) && live;
   assign mem_re  = (state_ff == S_EXEC) && (cmd_ff.kind == mcprb_pkg::K_READ) && live && !empty;
   assign chan_we = mem_we || mem_re;

   always_comb begin
      if (cmd_ff.kind == mcprb_pkg::K_WRITE) begin
         tail_in = wrap(tail, cap);
         head_in = full ? wrap(head, cap) : head;
         fill_in = full ? fill : fill + mcprb_pkg::SIZE_W'(1);
      end else begin
         tail_in = tail;
         head_in = wrap(head, cap);
         fill_in = fill - mcprb_pkg::SIZE_W'(1);
      end
   end

   // Result of any command but init, worked out in the execute cycle
   always_comb begin
      pend_status_in = mcprb_pkg::ST_OK;
      pend_fill_in   = fill;
      unique case (cmd_ff.kind)
         mcprb_pkg::K_WRITE: begin
            if (!live) begin
               pend_status_in = mcprb_pkg::ST_UNSIZED;
            end else begin
               pend_status_in = full ? mcprb_pkg::ST_OVERWRITE : mcprb_pkg::ST_OK;
               pend_fill_in   = fill_in;
            end
         end
         mcprb_pkg::K_READ: begin
            if (!live) begin
               pend_status_in = mcprb_pkg::ST_UNSIZED;
            end else if (empty) begin
               pend_status_in = mcprb_pkg::ST_EMPTY;
            end else begin
               pend_fill_in = fill_in;
            end
         end
         mcprb_pkg::K_PEEK: begin
            pend_status_in = mcprb_pkg::ST_OK;
         end
         mcprb_pkg::K_REJECT: begin
            pend_status_in = mcprb_pkg::ST_UNSIZED;
            pend_fill_in   = '0;
         end
         default: begin
            pend_status_in = mcprb_pkg::ST_OK;
            pend_fill_in   = '0;
         end
      endcase
   end

   // Layout walk, one channel a cycle
   assign wsize      = size_ff[mcprb_pkg::REG_IDX_W'(walk_ff)];
   assign sum_in     = sum_ff + mcprb_pkg::SUM_W'(wsize);
   assign bad_in     = bad_ff || (wsize > mcprb_pkg::MAX_CHAN_SIZE);
   assign walk_last  = (walk_ff == CHW'(CHANNEL_COUNT - 1));
   assign layout_bad = bad_in || (sum_in > mcprb_pkg::SUM_W'(MEM_DEPTH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE, S_DONE: begin
            if (cmd_pop) begin
               state_in = (cmd.kind == mcprb_pkg::K_INIT) ? S_WALK : S_EXEC;
            end else if (send) begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: state_in = S_DONE;
         S_WALK: state_in = walk_last ? S_DONE : S_WALK;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         sum_ff       <= '0;
         bad_ff       <= 1'b0;
         for (int i = 0; i < mcprb_pkg::REG_COUNT; i++) begin
            size_ff[i] <= '0;
         end
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            cap_ff[i]  <= '0;
            base_ff[i] <= '0;
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            size_ff[csr_index] <= csr_wdata;
         end
         if (cmd_pop) begin
            walk_ff <= '0;
            sum_ff  <= '0;
            bad_ff  <= 1'b0;
         end
         if (state_ff == S_WALK) begin
            cap_ff[walk_ff]  <= wsize;
            base_ff[walk_ff] <= BW'(sum_ff);
            head_ff[walk_ff] <= '0;
            tail_ff[walk_ff] <= '0;
            fill_ff[walk_ff] <= '0;
            walk_ff          <= walk_ff + CHW'(1);
            sum_ff           <= sum_in;
            bad_ff           <= bad_in;
            if (walk_last) begin
               ready_ff <= !layout_bad;
            end
         end
         if (chan_we) begin
            head_ff[sel] <= head_in;
            tail_ff[sel] <= tail_in;
            fill_ff[sel] <= fill_in;
         end
         if (send) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (state_ff == S_EXEC) begin
         pend_status_ff <= pend_status_in;
         pend_fill_ff   <= pend_fill_in;
         pend_read_ff   <= mem_re;
      end else if ((state_ff == S_WALK) && walk_last) begin
         pend_status_ff <= layout_bad ? mcprb_pkg::ST_LAYOUT : mcprb_pkg::ST_OK;
         pend_fill_ff   <= '0;
         pend_read_ff   <= 1'b0;
      end
      if (send) begin
         rsp_ff.rdata  <= pend_read_ff ? mem_q_ff : '0;
         rsp_ff.status <= pend_status_ff;
         rsp_ff.fill   <= pend_fill_ff;
      end
   end

   // Shared byte memory, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= cmd_ff.wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/multichannel_partitioned_ring_buffer_top.sv
// Top level of the multichannel partitioned ring buffer.
// Depends on mcprb_pkg, mcprb_front and mcprb_back.
`timescale 1ns / 1ps

// Up to CHANNEL_COUNT byte FIFOs share one memory of MEM_DEPTH bytes.
// Request channel (req_*): one word per action: write a byte, read a byte,
// init the layout, or no-op. A word is taken when req_valid is high and
// req_stall is low. Every request word yields exactly one result word.
// Result channel (rsp_*): rdata, status and the channel's fill after the
// action; a word moves when rsp_valid is high and rsp_stall is low.
// Size registers (csr_*): csr_index selects size_ch0..size_ch7, always
// ready; sizes take effect at the next init action.
// Timing: a request word passes through a two-word queue, then the back
// end runs an execute step (memory access plus pointer update) and then
// loads the result register. Byte action throughput is set by the single
// memory port and pointer update; the back end takes the next word only
// as it sends the current result. Init walks the channels one per cycle.
// A stalled receiver holds the result register; the back end then waits
// with its next result, and the queue fills and raises req_stall.
// Reset clears the queue, pointers, sizes and the layout-ready flag; byte
// actions answer "unsized" until an init succeeds. No clearing pass runs.

module multichannel_partitioned_ring_buffer_top #(
   parameter int CHANNEL_COUNT = mcprb_pkg::DEF_CHANNEL_COUNT,
   parameter int MEM_DEPTH     = mcprb_pkg::DEF_MEM_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mcprb_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mcprb_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mcprb_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mcprb_pkg::SIZE_W-1:0]     csr_wdata
);

   logic               cmd_valid;
   logic               cmd_pop;
   mcprb_pkg::cmd_type cmd;
   logic               csr_we;

   // Size registers take a word on every cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   mcprb_front #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   mcprb_back #(
      .CHANNEL_COUNT(CHANNEL_COUNT),
      .MEM_DEPTH    (MEM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/multichannel_partitioned_ring_buffer_top_tb.sv
// Self-checking testbench for multichannel_partitioned_ring_buffer_top.
// Depends on mcprb_pkg and the RTL under sv/; an internal ring model predicts
// every result word.
`timescale 1ns / 1ps

module multichannel_partitioned_ring_buffer_top_tb;
   import mcprb_pkg::*;

   localparam int NUM_CH        = DEF_CHANNEL_COUNT;
   localparam int MEM_BYTES     = DEF_MEM_DEPTH;
   localparam int HALF_CYCLE    = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int SHOW_LIMIT    = 10;
   localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

   // Clock, reset and DUT ports; every input starts at a known value
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   req_type              req_data   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [REG_IDX_W-1:0] csr_index  = '0;
   logic [SIZE_W-1:0]    csr_wdata  = '0;

   // Idle rates of the two sides, in percent of cycles
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int err_count   = 0;
   int cycle_count = 0;

   // Result words still owed by the DUT, oldest first
   rsp_type answer_q[$];

   // Ring model: size registers, latched layout, pointers, byte memory
   int unsigned      size_reg  [NUM_CH];
   int unsigned      chan_cap  [NUM_CH];
   int unsigned      chan_base [NUM_CH];
   int unsigned      chan_head [NUM_CH];
   int unsigned      chan_tail [NUM_CH];
   int unsigned      chan_fill [NUM_CH];
   bit               layout_ok = 1'b0;
   logic [DATA_W-1:0] ring_mem [MEM_BYTES];

   multichannel_partitioned_ring_buffer_top #(
      .CHANNEL_COUNT (NUM_CH),
      .MEM_DEPTH     (MEM_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_CYCLE clock = 1'b1;
      #HALF_CYCLE clock = 1'b0;
   end

   // Apply one action word to the ring model and return the result it owes.
   // Init latches the sizes, stacks channels by prefix sum and clears all
   // pointers; a full channel overwrites its oldest byte and drags head along.
   function automatic rsp_type ring_apply(req_type w);
      rsp_type     r;
      int unsigned sum;
      bit          bad;
      int unsigned ch;
      int unsigned cap;
      int unsigned addr;
      r   = '0;
      ch  = w.channel;
      if (w.action == ACT_INIT) begin
         sum = 0;
         bad = 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            if (size_reg[i] > MAX_CHAN_SIZE) bad = 1'b1;
            chan_cap[i]  = size_reg[i];
            chan_base[i] = sum;
            sum += size_reg[i];
            chan_head[i] = 0;
            chan_tail[i] = 0;
            chan_fill[i] = 0;
         end
         if (sum > MEM_BYTES) bad = 1'b1;
         layout_ok = !bad;
         r.status  = bad ? ST_LAYOUT : ST_OK;
         return r;
      end
      r.fill = SIZE_W'(chan_fill[ch]);
      if (w.action == ACT_NOP) return r;
      cap = chan_cap[ch];
      if (!layout_ok || cap == 0) begin
         r.status = ST_UNSIZED;
         return r;
      end
      if (w.action == ACT_WRITE) begin
         addr = chan_base[ch] + chan_tail[ch];
         if (addr < MEM_BYTES) ring_mem[addr] = w.wdata;
         if (chan_fill[ch] >= cap) begin
            chan_head[ch] = (chan_head[ch] + 1) % cap;
            r.status      = ST_OVERWRITE;
         end else begin
            chan_fill[ch]++;
         end
         chan_tail[ch] = (chan_tail[ch] + 1) % cap;
      end else if (chan_fill[ch] == 0) begin
         r.status = ST_EMPTY;
      end else begin
         addr          = chan_base[ch] + chan_head[ch];
         r.rdata       = (addr < MEM_BYTES) ? ring_mem[addr] : '0;
         chan_fill[ch]--;
         chan_head[ch] = (chan_head[ch] + 1) % cap;
      end
      r.fill = SIZE_W'(chan_fill[ch]);
      return r;
   endfunction

   function automatic req_type make_word(logic [ACTION_W-1:0] act, int ch, int data);
      req_type w;
      w.action  = act;
      w.channel = CHAN_W'(ch);
      w.wdata   = DATA_W'(data);
      return w;
   endfunction

   // Favor channels that hold a nonzero size so most traffic reaches the FIFOs
   function automatic int pick_channel();
      int sized[$];
      for (int i = 0; i < NUM_CH; i++)
         if (chan_cap[i] != 0) sized.push_back(i);
      if (sized.size() != 0 && $urandom_range(0, 99) < 85)
         return sized[$urandom_range(0, sized.size() - 1)];
      return $urandom_range(0, NUM_CH - 1);
   endfunction

   // Send one word. Call at a rising edge; returns at the edge that took it.
   // Valid stays high on return so back-to-back words need no gap.
   task automatic send_word(input req_type w);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answer_q.push_back(ring_apply(w));
   endtask

   // Drop valid and hold until every owed result word has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Write one size register; only called while the block is idle
   task automatic write_size(input int idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= REG_IDX_W'(idx);
      csr_wdata <= SIZE_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_reg[idx] = value & SIZE_FIELD_MAX;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly small channels so overwrite and empty come up often; now and
   // then an oversized channel, an overflowing sum, an exactly full memory,
   // or no sized channel at all.
   task automatic program_random_layout();
      int unsigned sz[NUM_CH];
      int unsigned others;
      int          roll;
      int          pick;
      int          victim;
      roll   = $urandom_range(0, 99);
      victim = $urandom_range(0, NUM_CH - 1);
      for (int i = 0; i < NUM_CH; i++) begin
         pick  = $urandom_range(0, 99);
         sz[i] = (pick < 15) ? 0 : (pick < 90) ? $urandom_range(1, 12)
                                               : $urandom_range(13, 600);
      end
      if (roll < 8) begin
         sz[victim] = $urandom_range(int'(MAX_CHAN_SIZE) + 1, SIZE_FIELD_MAX);
      end else if (roll < 14) begin
         foreach (sz[i]) sz[i] = MEM_BYTES / NUM_CH;
         sz[victim] += $urandom_range(1, 100);
      end else if (roll < 24) begin
         others = 0;
         foreach (sz[i]) if (i != victim) others += sz[i];
         sz[victim] = MEM_BYTES - others;
      end else if (roll < 28) begin
         foreach (sz[i]) sz[i] = 0;
      end
      for (int i = 0; i < NUM_CH; i++) write_size(i, sz[i]);
   endtask

   // Reads and writes before any init answer unsized; a no-op reports fill
   task automatic test_before_init();
      send_word(make_word(ACT_WRITE, 0, 8'hFF));
      send_word(make_word(ACT_READ, 5, 0));
      send_word(make_word(ACT_NOP, 2, 8'h00));
   endtask

   // A channel above the size limit, then a sum one past the memory
   task automatic test_layout_errors();
      wait_quiet();
      write_size(0, SIZE_FIELD_MAX);
      send_word(make_word(ACT_INIT, 0, 0));
      send_word(make_word(ACT_WRITE, 0, 8'h12));
      wait_quiet();
      for (int i = 0; i < NUM_CH; i++)
         write_size(i, (i == NUM_CH - 1) ? MEM_BYTES / NUM_CH + 1 : MEM_BYTES / NUM_CH);
      send_word(make_word(ACT_INIT, 0, 0));
      send_word(make_word(ACT_READ, 3, 0));
   endtask

   // Layout that fills the memory exactly, with an unsized channel; walk
   // order, overwrite of the oldest byte, empty read and the no-op.
   task automatic test_fifo_order();
      int sizes[NUM_CH] = '{2, 1, 0, 3, 4, 5, 6, MEM_BYTES - 21};
      wait_quiet();
      for (int i = 0; i < NUM_CH; i++) write_size(i, sizes[i]);
      send_word(make_word(ACT_INIT, 0, 0));
      send_word(make_word(ACT_WRITE, 0, 8'h00));
      send_word(make_word(ACT_WRITE, 0, 8'hFF));
      send_word(make_word(ACT_WRITE, 0, 8'hA5));
      send_word(make_word(ACT_READ, 0, 0));
      send_word(make_word(ACT_READ, 0, 0));
      send_word(make_word(ACT_READ, 0, 0));
      send_word(make_word(ACT_WRITE, 2, 8'h3C));
      send_word(make_word(ACT_READ, 2, 0));
      send_word(make_word(ACT_WRITE, 1, 8'h5A));
      send_word(make_word(ACT_WRITE, 1, 8'hC3));
      send_word(make_word(ACT_READ, 1, 0));
      send_word(make_word(ACT_WRITE, 7, 8'h81));
      send_word(make_word(ACT_NOP, 7, 8'h7E));
      send_word(make_word(ACT_READ, 7, 0));
   endtask

   // Random segments, each with a fresh layout and its own write/read mix
   task automatic test_random_traffic(input int n_words, input int s_pct, input int r_pct);
      int      sent;
      int      seg_len;
      int      write_pct;
      int      roll;
      req_type w;
      sender_idle_pct    = s_pct;
      receiver_stall_pct = r_pct;
      sent = 0;
      while (sent < n_words) begin
         wait_quiet();
         program_random_layout();
         send_word(make_word(ACT_INIT, 0, $urandom_range(0, 255)));
         sent++;
         seg_len   = layout_ok ? $urandom_range(40, 90) : $urandom_range(4, 10);
         write_pct = $urandom_range(30, 65);
         for (int k = 0; k < seg_len && sent < n_words; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < write_pct)  w.action = ACT_WRITE;
            else if (roll < 93)    w.action = ACT_READ;
            else if (roll < 97)    w.action = ACT_NOP;
            else                   w.action = ACT_INIT;
            w.channel = CHAN_W'(pick_channel());
            w.wdata   = DATA_W'($urandom_range(0, 255));
            send_word(w);
            sent++;
         end
      end
   endtask

   // Receiver side: stall at the current rate
   always @(posedge clock)
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(0, 99) < receiver_stall_pct);

   // Compare each accepted result word with the oldest owed one
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            err_count++;
            if (err_count <= SHOW_LIMIT)
               $display("unexpected result word: rdata=%0h status=%0d fill=%0d",
                        rsp_data.rdata, rsp_data.status, rsp_data.fill);
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.rdata !== want.rdata || rsp_data.status !== want.status ||
                rsp_data.fill !== want.fill) begin
               err_count++;
               if (err_count <= SHOW_LIMIT)
                  $display("mismatch: expected rdata=%0h status=%0d fill=%0d,",
                           want.rdata, want.status, want.fill,
                           " got rdata=%0h status=%0d fill=%0d",
                           rsp_data.rdata, rsp_data.status, rsp_data.fill);
            end
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multichannel_partitioned_ring_buffer_top test failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct    = 29;
      receiver_stall_pct = 87;
      test_before_init();
      test_layout_errors();
      test_fifo_order();
      test_random_traffic(350, 29, 87);
      test_random_traffic(350, 87, 29);
      test_random_traffic(350, 0, 0);
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0 && answer_q.size() == 0)
         $display("multichannel_partitioned_ring_buffer_top test passed");
      else
         $display("multichannel_partitioned_ring_buffer_top test failed");
      $finish;
   end

endmodule
